// ===== src/ckm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckm_pkg: shared definitions of the canonical k-mer minimizer seeder
// Register indexes, reset values, field widths and the ring entry layout.
// ----------------------------------------------------------------------------
package ckm_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_SEED_LENGTH = 2'd0;
	localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [1:0] REG_WINDOW_STEP = 2'd2;

	// Register reset values.
	localparam logic [4:0] SEED_LENGTH_RST = 5'd18;
	localparam logic [3:0] INDEX_BITS_RST  = 4'd0;
	localparam logic [5:0] WINDOW_STEP_RST = 6'd1;

	// Limits applied to register values.
	localparam logic [4:0] SEED_LENGTH_MIN = 5'd8;
	localparam logic [3:0] INDEX_BITS_MAX  = 4'd8;
	localparam logic [4:0] SEED_HIDDEN_K   = 5'd16;
	localparam logic [5:0] VALID_RUN_MAX   = 6'd63;

	localparam int MAX_WINDOW_DEF = 32;

	// Field widths.
	localparam int KMER_W   = 62;
	localparam int HASH_W   = 64;
	localparam int SEQ_W    = 24;
	localparam int POS_W    = 31;
	localparam int WORD_W   = 32;
	localparam int TINDEX_W = 8;

	// Xor-shift hash amounts.
	localparam int HASH_SHIFT_A = 14;
	localparam int HASH_SHIFT_B = 23;

	typedef struct packed {
		logic              strand;
		logic [HASH_W-1:0] hash;
		logic [KMER_W-1:0] kmer;
	} ring_entry_t;

endpackage

// ===== src/canonical_kmer_minimizer_seeder.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_minimizer_seeder
// Streams DNA bases, forms canonical k-mers with xor-shift hashes in a ring
// memory and emits the minimum-hash k-mer of every window as a seed.
// ----------------------------------------------------------------------------
// A base without a seed passes through the accept beat and the evaluation
// state. At a window end the ring memory is scanned one entry per cycle
// through its single read port, n = min(position, window_step) - 1 reads,
// and the seed is then loaded in the emit state; the next base can be taken
// once the block has returned to idle after that load.
// A waiting seed beat does not block the next base; only the next seed's
// emit step waits until it has been taken.
// Reset (arst_n low) restores the register defaults and clears the k-mer
// state and the ring valid bits at once; no clearing pass is needed.
module canonical_kmer_minimizer_seeder #(
	parameter int MAX_WINDOW = ckm_pkg::MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // base[1:0], sequence_id[25:2], zero fill
	input  logic [1:0]  s_tuser,   // base_valid[0], first_of_sequence[1]
	// Seed stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // seed_word[31:0], table_index[39:32],
	                               // seed_position[70:40], seed_sequence[94:71]
	output logic [0:0]  m_tuser,   // minus_strand[0]
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int RW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int STW = $clog2(MAX_WINDOW + 1);
	localparam int SCW = ((STW > 5) ? STW : 5) + 1;
	localparam int KW  = ckm_pkg::KMER_W;
	localparam int HW  = ckm_pkg::HASH_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// Configuration registers.
	logic [4:0] seed_length_q;
	logic [3:0] index_bits_q;
	logic [5:0] window_step_q;

	// Sequence state.
	logic [1:0]            state_q;
	logic [63:0]           fwd_q;
	logic [63:0]           rev_q;
	logic [5:0]            run_q;
	logic [31:0]           pos_q;
	logic signed [SCW-1:0] step_count_q;
	logic [RW-1:0]         slot_q;
	logic [MAX_WINDOW-1:0] vbit_q;

	// Item under evaluation.
	logic [KW-1:0]            x_s1;
	logic [KW-1:0]            xr_s1;
	logic [ckm_pkg::SEQ_W-1:0] seq_s1;

	// Scan state.
	logic [RW-1:0]  slot_scan_q;
	logic [STW-1:0] i_q;
	logic [STW-1:0] n_q;
	logic           rd_pend_q;
	logic [STW-1:0] rd_i_q;
	logic           rd_vld_q;
	ckm_pkg::ring_entry_t rd_data_q;
	logic [KW-1:0]  best_kmer_q;
	logic [HW-1:0]  best_hash_q;
	logic           best_strand_q;
	logic [STW-1:0] best_dx_q;

	// Output register.
	logic        m_tvalid_q;
	logic [95:0] out_data_q;
	logic        out_minus_q;

	ckm_pkg::ring_entry_t ring_mem [MAX_WINDOW];

	// Effective register values.
	logic [4:0]     k;
	logic [5:0]     k2;
	logic [6:0]     shamt;
	logic [KW-1:0]  mask;
	logic [STW-1:0] step;
	logic [3:0]     ib;

	always_comb begin
		k = (seed_length_q < ckm_pkg::SEED_LENGTH_MIN) ? ckm_pkg::SEED_LENGTH_MIN
			: seed_length_q;
		k2 = {k, 1'b0};
		shamt = 7'd64 - {1'b0, k2};
		mask = KW'((64'd1 << k2) - 64'd1);
		if (window_step_q == 6'd0) begin
			step = STW'(1);
		end else if (32'(window_step_q) > MAX_WINDOW) begin
			step = STW'(MAX_WINDOW);
		end else begin
			step = STW'(window_step_q);
		end
		ib = (index_bits_q > ckm_pkg::INDEX_BITS_MAX) ? ckm_pkg::INDEX_BITS_MAX
			: index_bits_q;
	end

	// Accept beat: shift the base into both k-mer registers.
	logic        accept;
	logic [1:0]  in_base;
	logic        in_bvalid;
	logic        in_first;
	logic [63:0] fwd_base;
	logic [63:0] rev_base;
	logic [5:0]  run_base;
	logic [63:0] fwd_new;
	logic [63:0] rev_new;
	logic [5:0]  run_new;

	always_comb begin
		in_base = s_tdata[1:0];
		in_bvalid = s_tuser[0];
		in_first = s_tuser[1];
		accept = s_tvalid && s_tready;
		fwd_base = in_first ? 64'd0 : fwd_q;
		rev_base = in_first ? 64'd0 : rev_q;
		run_base = in_first ? 6'd0 : run_q;
		fwd_new = {fwd_base[61:0], (in_bvalid ? in_base : 2'b00)};
		rev_new = {(in_bvalid ? ~in_base : 2'b00), rev_base[63:2]};
		if (!in_bvalid) begin
			run_new = 6'd0;
		end else if (run_base < ckm_pkg::VALID_RUN_MAX) begin
			run_new = run_base + 6'd1;
		end else begin
			run_new = run_base;
		end
	end

	// Evaluation: canonical choice, hash, rejection tests, window end.
	logic                  minus;
	logic [KW-1:0]         zc;
	logic [KW-1:0]         z;
	logic [HW-1:0]         h;
	logic                  reject;
	logic [RW-1:0]         slot_eff;
	logic [RW-1:0]         slot_next;
	logic signed [SCW-1:0] step_sc;
	logic signed [SCW-1:0] sc_adj;
	logic                  window_end;
	logic signed [31:0]    lim;
	logic [STW-1:0]        n_new;

	always_comb begin
		minus = x_s1 > xr_s1;
		zc = minus ? xr_s1 : x_s1;
		h = {2'b00, zc} ^ ({2'b00, zc} << ckm_pkg::HASH_SHIFT_A)
			^ ({2'b00, zc} << ckm_pkg::HASH_SHIFT_B);
		// Homopolymers and period-2 repeats are not useful seeds.
		reject = (run_q < {1'b0, k})
			|| ((x_s1 >> 2) == (x_s1 & (mask >> 2)))
			|| ((x_s1 >> 4) == (x_s1 & (mask >> 4)));
		z = reject ? '0 : zc;
		slot_eff = (STW'(slot_q) < step) ? slot_q : '0;
		slot_next = (({1'b0, STW'(slot_eff)} + (STW+1)'(1)) >= {1'b0, step}) ? '0
			: RW'(STW'(slot_eff) + STW'(1));
		step_sc = $signed(SCW'(step));
		sc_adj = (step_count_q >= step_sc) ? '0 : step_count_q;
		window_end = (sc_adj == '0);
		lim = ($signed(pos_q) < $signed(32'(step))) ? $signed(pos_q)
			: $signed(32'(step));
		n_new = (lim > 32'sd1) ? STW'(lim - 32'sd1) : '0;
	end

	// Scan read address: i entries back from the window's last slot.
	logic           issue;
	logic [STW:0]   slot_ext;
	logic [RW-1:0]  rd_addr;
	logic           rd_better;

	always_comb begin
		issue = (state_q == ST_SCAN) && (i_q <= n_q);
		slot_ext = (STW+1)'(slot_scan_q);
		if (slot_ext >= {1'b0, i_q}) begin
			rd_addr = RW'(slot_ext - {1'b0, i_q});
		end else begin
			rd_addr = RW'(slot_ext + {1'b0, step} - {1'b0, i_q});
		end
		// Strict compare: on a tie the more recent k-mer stays chosen.
		rd_better = rd_pend_q && rd_vld_q && (rd_data_q.kmer != '0)
			&& (rd_data_q.hash < best_hash_q);
	end

	logic mem_we;
	logic emit_load;

	assign mem_we = (state_q == ST_EVAL);
	assign emit_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// Seed fields.
	logic [4:0]                    hidden2;
	logic [8:0]                    tmask;
	logic [ckm_pkg::WORD_W-1:0]    seed_word;
	logic [ckm_pkg::TINDEX_W-1:0]  table_index;
	logic [31:0]                   pos_full;

	always_comb begin
		hidden2 = (k > ckm_pkg::SEED_HIDDEN_K) ? 5'({k - ckm_pkg::SEED_HIDDEN_K, 1'b0})
			: 5'd0;
		seed_word = ckm_pkg::WORD_W'(best_kmer_q >> hidden2);
		tmask = (9'd1 << ib) - 9'd1;
		table_index = best_kmer_q[ckm_pkg::TINDEX_W-1:0] & tmask[7:0];
		// The position counter already stands one past the current base.
		pos_full = pos_q - 32'(best_dx_q);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_length_q <= ckm_pkg::SEED_LENGTH_RST;
			index_bits_q <= ckm_pkg::INDEX_BITS_RST;
			window_step_q <= ckm_pkg::WINDOW_STEP_RST;
			state_q <= ST_IDLE;
			fwd_q <= '0;
			rev_q <= '0;
			run_q <= '0;
			pos_q <= 32'd1 - 32'(ckm_pkg::SEED_LENGTH_RST);
			step_count_q <= SCW'(1) - SCW'(ckm_pkg::SEED_LENGTH_RST);
			slot_q <= '0;
			vbit_q <= '0;
			i_q <= '0;
			rd_pend_q <= 1'b0;
			rd_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ckm_pkg::REG_SEED_LENGTH: seed_length_q <= cfg_data[4:0];
					ckm_pkg::REG_INDEX_BITS:  index_bits_q <= cfg_data[3:0];
					ckm_pkg::REG_WINDOW_STEP: window_step_q <= cfg_data;
					default: ;
				endcase
			end

			if (emit_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fwd_q <= fwd_new;
						rev_q <= rev_new;
						run_q <= run_new;
						if (in_first) begin
							pos_q <= 32'd1 - 32'(k);
							step_count_q <= SCW'(1) - SCW'(k);
							slot_q <= '0;
							vbit_q <= '0;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					vbit_q[slot_eff] <= 1'b1;
					slot_q <= slot_next;
					pos_q <= pos_q + 32'd1;
					if (window_end && (z != '0)) begin
						i_q <= STW'(1);
						state_q <= ST_SCAN;
					end else begin
						// An invalid k-mer at a window end retries at the next base.
						step_count_q <= window_end ? '0 : sc_adj + SCW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rd_pend_q <= issue;
					if (issue) begin
						rd_vld_q <= vbit_q[rd_addr];
						i_q <= i_q + STW'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						// The next window starts right after the chosen k-mer.
						step_count_q <= SCW'(best_dx_q) + SCW'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= fwd_new[KW-1:0] & mask;
			xr_s1 <= KW'(rev_new >> shamt) & mask;
			seq_s1 <= s_tdata[25:2];
		end
		if (state_q == ST_EVAL) begin
			slot_scan_q <= slot_eff;
			n_q <= n_new;
			best_kmer_q <= z;
			best_hash_q <= h;
			best_strand_q <= minus;
			best_dx_q <= '0;
		end
		if (issue) begin
			rd_i_q <= i_q;
		end
		if ((state_q == ST_SCAN) && rd_better) begin
			best_kmer_q <= rd_data_q.kmer;
			best_hash_q <= rd_data_q.hash;
			best_strand_q <= rd_data_q.strand;
			best_dx_q <= rd_i_q;
		end
		if (emit_load) begin
			out_data_q <= {1'b0, seq_s1, pos_full[ckm_pkg::POS_W-1:0], table_index,
				seed_word};
			out_minus_q <= best_strand_q;
		end
	end

	// Ring memory: one write port for evaluation, one read port for the scan.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[slot_eff] <= '{strand: minus, hash: h, kmer: z};
		end
		if (issue) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_minus_q;
	assign cfg_ready = 1'b1;

	// The scan never reads the slot that holds the current k-mer.
	assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (rd_addr != slot_scan_q) && (STW'(rd_addr) < step))
		else $error("scan address outside the window or on the current slot");

	// A seed beat only starts out of the emit state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("seed beat raised outside the emit state");

	// The chosen k-mer lies within the scanned part of the window.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (best_dx_q <= n_q))
		else $error("chosen k-mer beyond the scanned entries");

	// No base is taken while a window scan is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> !$past(accept))
		else $error("base accepted during a window scan");

endmodule
